FILE: design/nct_pkg.sv
// Shared types, constants and helpers of the nearest-centroid tracker.
package nct_pkg;

  localparam int SLOTS = 8;
  localparam int HEADS = 4;

  localparam logic [15:0] ID_FIRST = 16'd100;
  localparam logic [15:0] ID_LAST  = 16'd32767;
  localparam logic [15:0] ID_NONE  = 16'hFFFF;
  localparam logic [9:0]  WIDTH_RESET  = 10'd704;
  localparam logic [9:0]  HEIGHT_RESET = 10'd480;

  localparam logic       CMD_MOTION = 1'b0;
  localparam logic       CMD_HEAD   = 1'b1;
  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_VALID = 2'd1;
  localparam logic [1:0] CODE_WEAK  = 2'd2;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [2:0] slot;
    logic [1:0] head_index;
    logic [1:0] valid_req;
    logic [9:0] x0;
    logic [9:0] y0;
    logic [9:0] x1;
    logic [9:0] y1;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic               locked;
    logic signed [15:0] track_id;
    logic [1:0]         box_valid;
    logic [9:0]         box_x0;
    logic [9:0]         box_y0;
    logic [9:0]         box_x1;
    logic [9:0]         box_y1;
    logic signed [11:0] head_x0;
    logic signed [11:0] head_y0;
    logic signed [11:0] head_x1;
    logic signed [11:0] head_y1;
    logic               last_slot;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [9:0]  x0;
    logic [9:0]  y0;
    logic [9:0]  x1;
    logic [9:0]  y1;
  } item_t;

  typedef struct packed {
    logic               lock;
    logic signed [15:0] id;
    logic [1:0]         code;
    logic [9:0]         b0;
    logic [9:0]         b1;
    logic [9:0]         b2;
    logic [9:0]         b3;
    logic signed [11:0] h0;
    logic signed [11:0] h1;
    logic signed [11:0] h2;
    logic signed [11:0] h3;
  } trk_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_COPY, ST_TRK_RD, ST_BOX, ST_HEAD_RD, ST_HEAD, ST_DST,
    ST_DIV, ST_PLACE, ST_DUP_RD, ST_DUP, ST_DUP_HD, ST_DUP_HW,
    ST_NEW_RD, ST_NEW, ST_CLEAR, ST_EMIT_RD, ST_EMIT
  } state_t;

  function automatic trk_t empty_trk();
    trk_t t;
    t = '0;
    t.id = ID_NONE;
    return t;
  endfunction

  function automatic logic signed [12:0] mid(input logic signed [12:0] a,
                                            input logic signed [12:0] b);
    logic signed [13:0] d;
    logic signed [13:0] q;
    d = 14'(b) - 14'(a);
    q = (d < 0) ? -((-d) >>> 1) : (d >>> 1);
    return 13'(14'(a) + q);
  endfunction

  function automatic logic head_ok(input logic [1:0] v);
    return v == CODE_VALID || v == CODE_WEAK;
  endfunction

endpackage

FILE: design/nct_div.sv
// Restoring divider for the head rescale: one quotient bit per cycle.
module nct_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [23:0] num,
  input  logic signed [11:0] den,
  output logic        busy,
  output logic signed [23:0] quo
);
  import nct_pkg::*;

  logic [23:0] n_mag;
  logic [11:0] d_mag;
  logic [24:0] rem;
  logic [4:0]  count;
  logic        neg;
  logic [24:0] trial;

  assign trial = {rem[23:0], n_mag[23]} - {13'd0, d_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd24;
      n_mag <= num[23] ? 24'(-num) : num;
      d_mag <= den[11] ? 12'(-den) : den;
      neg   <= num[23] ^ den[11];
      rem   <= '0;
    end else if (busy) begin
      if (trial[24]) begin
        rem <= {rem[23:0], n_mag[23]};
        n_mag <= {n_mag[22:0], 1'b0};
      end else begin
        rem <= trial;
        n_mag <= {n_mag[22:0], 1'b1};
      end
      count <= count - 5'd1;
      if (count == 5'd1) busy <= 1'b0;
    end
  end

  assign quo = neg ? 24'(-n_mag) : n_mag;
endmodule

FILE: design/nct_core.sv
// Frame buffers, track tables and the per-frame tracking sequencer.
module nct_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [9:0]          frame_width,
  input  logic [9:0]          frame_height,
  input  logic                in_valid,
  output logic                in_ready,
  input  nct_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nct_pkg::out_word_t  out_data
);
  import nct_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = $clog2(HEADS + 1);

  // small stores kept in registers, read by scan index
  item_t       mot   [SLOTS];
  item_t       heads [SLOTS][HEADS];
  trk_t        trk   [SLOTS];
  trk_t        prv   [SLOTS];
  logic [1:0]  lcnt  [SLOTS];
  logic [15:0] next_id;

  state_t      state, state_next;
  logic [CW-1:0] t, m;
  logic [KW-1:0] k;
  logic [SW-1:0] near, dst;
  logic          found;
  logic [HW-1:0] hk;
  logic          hfound;
  logic [20:0]   best;
  logic [2:0]    same;
  logic          div_phase;
  logic          div_wait;
  logic signed [23:0] hw_q, hh_q;
  logic        emit_ok;

  logic [SW-1:0] ti, mi;
  logic [HW-1:0] ki;
  assign ti = t[SW-1:0];
  assign mi = m[SW-1:0];
  assign ki = k[HW-1:0];

  trk_t p;
  assign p = prv[ti];
  logic signed [12:0] cx, cy;
  assign cx = mid(13'(p.h0), 13'(p.h2));
  assign cy = mid(13'(p.h1), 13'(p.h3));

  // squared distance of a candidate centre to the track centre
  function automatic logic [21:0] sq_dist(input logic signed [12:0] ax,
      input logic signed [12:0] ay, input logic signed [12:0] bx,
      input logic signed [12:0] by);
    logic signed [13:0] dx, dy;
    dx = 14'(ax) - 14'(bx);
    dy = 14'(ay) - 14'(by);
    return 22'(dx * dx) + 22'(dy * dy);
  endfunction

  function automatic trk_t seed_trk(input item_t it);
    trk_t r;
    r = empty_trk();
    if (it.code == CODE_VALID) begin
      r.code = CODE_VALID;
      r.b0 = it.x0; r.b1 = it.y0; r.b2 = it.x1; r.b3 = it.y1;
    end
    return r;
  endfunction

  item_t cm, chd;
  assign cm  = mot[mi];
  assign chd = heads[near][ki];
  logic [21:0] dbox, dhead;
  assign dbox = sq_dist(mid({3'b0, cm.x0}, {3'b0, cm.x1}),
                        mid({3'b0, cm.y0}, {3'b0, cm.y1}), cx, cy);
  assign dhead = sq_dist(mid({3'b0, chd.x0}, {3'b0, chd.x1}),
                         mid({3'b0, chd.y0}, {3'b0, chd.y1}), cx, cy);

  item_t nb;
  assign nb = mot[near];
  logic signed [11:0] nw, nh, ow, oh, phw, phh;
  assign nw  = 12'(nb.x1) - 12'(nb.x0);
  assign nh  = 12'(nb.y1) - 12'(nb.y0);
  assign ow  = 12'(p.b2) - 12'(p.b0);
  assign oh  = 12'(p.b3) - 12'(p.b1);
  assign phw = p.h2 - p.h0;
  assign phh = p.h3 - p.h1;

  logic               div_start, div_busy;
  logic signed [23:0] div_num, div_quo;
  logic signed [11:0] div_den;
  logic signed [23:0] prod;
  assign prod = div_phase ? phh * nh : phw * nw;
  assign div_num = prod;
  assign div_den = div_phase ? oh : ow;

  nct_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  logic [20:0] mbound, wbound;
  assign mbound = 21'(frame_width * frame_height);
  assign wbound = 21'(frame_width * frame_width);

  logic signed [12:0] nx;
  assign nx = mid({3'b0, nb.x0}, {3'b0, nb.x1});
  function automatic logic signed [23:0] half(input logic signed [23:0] v);
    return (v < 0) ? -((-v) >>> 1) : (v >>> 1);
  endfunction
  logic signed [23:0] rh0, rh1, rh2, rh3;
  assign rh0 = 24'(nx) - half(hw_q);
  assign rh2 = 24'(nx) + half(hw_q);
  assign rh1 = 24'(cy) - half(hh_q);
  assign rh3 = 24'(cy) + half(hh_q);
  logic head_in;
  assign head_in = rh0 >= $signed({14'd0, nb.x0}) && rh1 >= $signed({14'd0, nb.y0}) &&
                   rh2 <= $signed({14'd0, nb.x1}) && rh3 <= $signed({14'd0, nb.y1});

  trk_t placed;
  always_comb begin
    placed      = empty_trk();
    placed.lock = 1'b1;
    placed.id   = p.id;
    placed.code = nb.code;
    placed.b0 = nb.x0; placed.b1 = nb.y0;
    placed.b2 = nb.x1; placed.b3 = nb.y1;
    if (hfound) begin
      placed.h0 = 12'(heads[near][hk].x0);
      placed.h1 = 12'(heads[near][hk].y0);
      placed.h2 = 12'(heads[near][hk].x1);
      placed.h3 = 12'(heads[near][hk].y1);
    end else if (head_in) begin
      placed.h0 = 12'(rh0); placed.h1 = 12'(rh1);
      placed.h2 = 12'(rh2); placed.h3 = 12'(rh3);
    end else begin
      placed = empty_trk();
    end
  end

  trk_t tt, tm;
  assign tt = trk[ti];
  assign tm = trk[mi];

  trk_t dup_trk;
  always_comb begin
    dup_trk      = tm;
    dup_trk.lock = 1'b1;
    dup_trk.h0   = 12'(heads[ti][ki].x0);
    dup_trk.h1   = 12'(heads[ti][ki].y0);
    dup_trk.h2   = 12'(heads[ti][ki].x1);
    dup_trk.h3   = 12'(heads[ti][ki].y1);
  end

  trk_t fresh_trk;
  always_comb begin
    fresh_trk      = empty_trk();
    fresh_trk.lock = 1'b1;
    fresh_trk.id   = next_id;
    fresh_trk.code = mot[ti].code;
    fresh_trk.b0 = mot[ti].x0; fresh_trk.b1 = mot[ti].y0;
    fresh_trk.b2 = mot[ti].x1; fresh_trk.b3 = mot[ti].y1;
    fresh_trk.h0 = 12'(heads[ti][ki].x0);
    fresh_trk.h1 = 12'(heads[ti][ki].y0);
    fresh_trk.h2 = 12'(heads[ti][ki].x1);
    fresh_trk.h3 = 12'(heads[ti][ki].y1);
  end

  logic slot_ok;
  assign slot_ok = 32'(in_data.slot) < SLOTS;

  assign in_ready = (state == ST_LOAD);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_LOAD:    if (in_valid && in_data.frame_end) state_next = ST_COPY;
      ST_COPY:    state_next = ST_TRK_RD;
      ST_TRK_RD:  if (32'(t) == SLOTS) state_next = ST_DUP_RD;
                  else if (p.lock) state_next = ST_BOX;
      ST_BOX:     if (32'(m) == SLOTS) state_next = found ? ST_HEAD_RD : ST_TRK_RD;
      ST_HEAD_RD: state_next = ST_HEAD;
      ST_HEAD:    if (32'(k) == HEADS) state_next = ST_DST;
      ST_DST:     if (32'(m) == SLOTS || mot[mi].code == CODE_NONE ||
                      lcnt[near] != 2'd1)
                    state_next = hfound ? ST_PLACE : ST_DIV;
      ST_DIV:     div_start = !div_busy && !div_wait;
      ST_PLACE:   state_next = ST_TRK_RD;
      ST_DUP_RD:  if (32'(t) == SLOTS) state_next = ST_NEW_RD;
                  else if (tt.code == CODE_VALID) state_next = ST_DUP;
      ST_DUP:     if (32'(m) == SLOTS) state_next = ST_DUP_RD;
      ST_DUP_HD:  state_next = ST_DUP;
      ST_DUP_HW:  state_next = ST_DUP;
      ST_NEW_RD:  if (32'(t) == SLOTS) state_next = ST_CLEAR;
      ST_NEW:     state_next = ST_NEW_RD;
      ST_CLEAR:   state_next = ST_EMIT;
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT:    if (out_ready && 32'(t) == SLOTS - 1) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      next_id <= ID_FIRST;
      for (int i = 0; i < SLOTS; i++) begin
        mot[i]  <= '0;
        trk[i]  <= empty_trk();
        prv[i]  <= empty_trk();
        lcnt[i] <= '0;
        for (int j = 0; j < HEADS; j++) heads[i][j] <= '0;
      end
      t <= '0; m <= '0; k <= '0;
      div_phase <= 1'b0;
      div_wait  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_valid && slot_ok) begin
            if (in_data.cmd == CMD_MOTION)
              mot[in_data.slot[SW-1:0]] <= {in_data.valid_req, in_data.x0,
                  in_data.y0, in_data.x1, in_data.y1};
            else if (32'(in_data.head_index) < HEADS)
              heads[in_data.slot[SW-1:0]][in_data.head_index[HW-1:0]] <=
                  {in_data.valid_req, in_data.x0, in_data.y0, in_data.x1,
                   in_data.y1};
          end
          state <= state_next;
        end
        ST_COPY: begin
          for (int i = 0; i < SLOTS; i++) begin
            prv[i]  <= trk[i];
            trk[i]  <= seed_trk(mot[i]);
            lcnt[i] <= '0;
          end
          t <= '0;
          state <= state_next;
        end
        ST_TRK_RD: begin
          if (32'(t) != SLOTS) begin
            if (p.lock) begin
              m <= '0; found <= 1'b0; best <= mbound;
            end else t <= t + 1'b1;
          end else begin
            t <= '0;
          end
          state <= state_next;
        end
        ST_BOX: begin
          if (32'(m) != SLOTS) begin
            if (cm.code == CODE_VALID && dbox < {1'b0, best}) begin
              best <= dbox[20:0]; near <= mi; found <= 1'b1;
            end
            m <= m + 1'b1;
          end else if (!found) begin
            trk[ti] <= empty_trk();
            t <= t + 1'b1;
          end
          state <= state_next;
        end
        ST_HEAD_RD: begin
          k <= '0; hfound <= 1'b0; best <= wbound;
          state <= state_next;
        end
        ST_HEAD: begin
          if (32'(k) != HEADS) begin
            if (head_ok(chd.code) && dhead < {1'b0, best}) begin
              best <= dhead[20:0]; hk <= ki; hfound <= 1'b1;
            end
            k <= k + 1'b1;
          end else begin
            m <= '0; dst <= '0;
          end
          state <= state_next;
        end
        ST_DST: begin
          if (lcnt[near] != 2'd1) dst <= near;
          else if (32'(m) != SLOTS && mot[mi].code == CODE_NONE) dst <= mi;
          else if (32'(m) != SLOTS) m <= m + 1'b1;
          div_phase <= 1'b0;
          div_wait  <= 1'b0;
          state <= state_next;
        end
        ST_DIV: begin
          // two divisions, width then height; zero old size gives zero
          if (!div_busy && !div_wait) begin
            div_wait <= 1'b1;
          end else if (!div_busy && div_wait) begin
            if (!div_phase) hw_q <= (ow == 0) ? 24'sd0 : div_quo;
            else            hh_q <= (oh == 0) ? 24'sd0 : div_quo;
            div_wait  <= 1'b0;
            div_phase <= !div_phase;
            if (div_phase) state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          trk[dst] <= placed;
          if ((hfound || head_in) && lcnt[dst] != 2'd3) lcnt[dst] <= lcnt[dst] + 2'd1;
          t <= t + 1'b1;
          state <= state_next;
        end
        ST_DUP_RD: begin
          if (32'(t) != SLOTS) begin
            if (tt.code == CODE_VALID) begin
              m <= '0; same <= '0;
            end else t <= t + 1'b1;
          end else t <= '0;
          state <= state_next;
        end
        ST_DUP: begin
          if (32'(m) == SLOTS) begin
            t <= t + 1'b1;
            state <= state_next;
          end else if (tm.code != CODE_VALID || m == t) begin
            m <= m + 1'b1;
          end else begin
            logic [2:0] s2;
            s2 = same + ((tt.b0 == tm.b0 && tt.b1 == tm.b1 && tt.b2 == tm.b2 &&
                 tt.b3 == tm.b3 && tt.h0 == tm.h0 && tt.h1 == tm.h1 &&
                 tt.h2 == tm.h2 && tt.h3 == tm.h3) ? 3'd1 : 3'd0);
            same <= (s2 > 3'd2) ? 3'd2 : s2;
            if (s2 == 3'd1) begin
              k <= '0;
              state <= ST_DUP_HD;
            end else m <= m + 1'b1;
          end
        end
        ST_DUP_HD: begin
          if (32'(k) == HEADS) begin
            trk[mi] <= empty_trk();
            m <= m + 1'b1;
            state <= ST_DUP;
          end else if (head_ok(heads[mi][ki].code) &&
                       tm.h0 != 12'(heads[ti][ki].x0)) begin
            trk[mi] <= dup_trk;
            m <= m + 1'b1;
            state <= ST_DUP;
          end else begin
            k <= k + 1'b1;
            state <= ST_DUP_HD;
          end
        end
        ST_DUP_HW: state <= ST_DUP;
        ST_NEW_RD: begin
          if (32'(t) != SLOTS) begin
            if (lcnt[ti] != 2'd0 || tt.code != CODE_VALID) t <= t + 1'b1;
            else begin
              k <= '0; state <= ST_NEW;
            end
          end else begin
            state <= ST_CLEAR;
          end
        end
        ST_NEW: begin
          if (32'(k) == HEADS) begin
            trk[ti] <= empty_trk();
            t <= t + 1'b1;
            state <= ST_NEW_RD;
          end else if (heads[ti][ki].code == CODE_VALID) begin
            trk[ti] <= fresh_trk;
            next_id <= (next_id >= ID_LAST) ? ID_FIRST : next_id + 16'd1;
            t <= t + 1'b1;
            state <= ST_NEW_RD;
          end else k <= k + 1'b1;
        end
        ST_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            mot[i] <= '0;
            for (int j = 0; j < HEADS; j++) heads[i][j] <= '0;
          end
          t <= '0;
          state <= state_next;
        end
        ST_EMIT: begin
          if (out_ready) t <= t + 1'b1;
          state <= state_next;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign emit_ok  = (state == ST_EMIT);
  assign out_valid = emit_ok;
  always_comb begin
    out_data = '0;
    out_data.locked    = tt.lock;
    out_data.track_id  = tt.id;
    out_data.box_valid = tt.code;
    out_data.box_x0 = tt.b0; out_data.box_y0 = tt.b1;
    out_data.box_x1 = tt.b2; out_data.box_y1 = tt.b3;
    out_data.head_x0 = tt.h0; out_data.head_y0 = tt.h1;
    out_data.head_x1 = tt.h2; out_data.head_y1 = tt.h3;
    out_data.last_slot = (32'(t) == SLOTS - 1);
  end
endmodule

FILE: design/nearest_centroid_object_tracker.sv
// Top level of the nearest-centroid tracker: configuration registers and core.
//  channel | dir | word
//  in      | in  | nct_pkg::in_word_t, one box or head candidate
//  out     | out | nct_pkg::out_word_t, one per slot after a frame end
//  cfg     | in  | cfg_index selects width (0) or height (1)
// Loading accepts one word per cycle while in_ready is high. A frame end runs
// the sequencer: a search for each locked track, plus two divisions when no head
// is found, then a scan for duplicates and one for new tracks, then SLOTS
// result words, one a cycle while out_ready is high.
// Reset is synchronous; input stalls from the frame end until the last word is taken.
module nearest_centroid_object_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nct_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nct_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import nct_pkg::*;

  logic [9:0] frame_width, frame_height;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  nct_core u_core (
    .clk, .rst, .frame_width, .frame_height,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );
endmodule

FILE: design/nct_checker.sv
// Port-level checks for the tracker, bound to the top level.
module nct_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid) else $error("extra result");
endmodule

bind nearest_centroid_object_tracker nct_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_last(out_data.last_slot)
);
